// File: hw/rtl/ont_pkg.sv
package ont_pkg;

  // default table geometry
  localparam int DEPTH_DEF      = 128;
  localparam int NAME_BYTES_DEF = 8;

  // fixed field widths
  localparam int KEY_W  = 64;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int OUT_W  = 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

// File: hw/rtl/ont_mem.sv
module ont_mem
  import ont_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = KEY_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/ordered_name_table.sv
// Ordered table of distinct name keys held in one synchronous memory plus an
// entry count. Each command (create, delete, search) gives exactly one result
// holding a status, a one-based position and the count after the command.
// Commands are handled one at a time. A lookup streams the table through the
// memory read port at one entry per cycle and stops at the first match, or at
// the last entry when the key is absent. A delete then moves every later entry
// down one place, one entry per cycle through the same read and write ports.
// A full table on create, an empty table and the unknown command code skip the
// scan and go straight to the result. The next command is taken once the result
// is in the output register.
module ordered_name_table
  import ont_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [KEY_W-1:0] in_name_key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [OUT_W-1:0] out_position,
  output logic [OUT_W-1:0] out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = 8 * NAME_BYTES;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_FIN,
    S_SHIFT,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              rv_r, rv_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     slot_r, slot_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [CW-1:0]     res_pos_r, res_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [OUT_W-1:0]  out_pos_r, out_pos_nxt;
  logic [OUT_W-1:0]  out_count_r, out_count_nxt;

  logic              in_xfer;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [KW-1:0]     mem_wr_data;
  logic              mem_rd_en;
  logic [KW-1:0]     mem_rd_data;
  logic              cmp_hit;
  logic [CW+OUT_W-1:0] pos_wide;
  logic [CW+OUT_W-1:0] count_wide;

  // key storage
  ont_mem #(
    .DEPTH (DEPTH),
    .WIDTH (KW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cmp_hit  = (mem_rd_data == key_r);

  // position and count cut to the result field width
  assign pos_wide   = {{OUT_W{1'b0}}, res_pos_r};
  assign count_wide = {{OUT_W{1'b0}}, count_r};

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    rv_nxt         = 1'b0;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = rd_idx_r[AW-1:0];
    mem_wr_data    = key_r;
    mem_rd_en      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt    = in_cmd;
          key_nxt    = in_name_key[KW-1:0];
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          // scan only when the command needs it and there is something to scan
          if (count_r != '0 &&
              ((in_cmd == CMD_CREATE && count_r < DEPTH_C) ||
               in_cmd == CMD_DELETE || in_cmd == CMD_SEARCH)) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_SEARCH: begin
        // one read issued per cycle, its data compared in the following cycle
        mem_rd_en   = 1'b1;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        cmp_idx_nxt = rd_idx_r;
        rv_nxt      = 1'b1;
        if (rv_r) begin
          if (cmp_hit) begin
            found_nxt = 1'b1;
            slot_nxt  = cmp_idx_r;
            rv_nxt    = 1'b0;
            state_nxt = S_FIN;
          end else if (cmp_idx_r == count_r - 1'b1) begin
            found_nxt = 1'b0;
            rv_nxt    = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        state_nxt      = S_OUT;
        res_status_nxt = ST_MISSING;
        res_pos_nxt    = '0;
        case (cmd_r)
          CMD_CREATE: begin
            if (count_r >= DEPTH_C) begin
              res_status_nxt = ST_FULL;
            end else if (found_r) begin
              res_status_nxt = ST_EXISTS;
            end else begin
              // append at the end
              mem_wr_en      = 1'b1;
              mem_wr_addr    = count_r[AW-1:0];
              count_nxt      = count_r + 1'b1;
              res_status_nxt = ST_OK;
              res_pos_nxt    = count_r + 1'b1;
            end
          end
          CMD_DELETE: begin
            if (found_r) begin
              rd_idx_nxt = slot_r + 1'b1;
              state_nxt  = S_SHIFT;
            end
          end
          CMD_SEARCH: begin
            if (found_r) begin
              res_status_nxt = ST_OK;
              res_pos_nxt    = slot_r + 1'b1;
            end
          end
          default: begin
            res_status_nxt = ST_MISSING;
          end
        endcase
      end

      S_SHIFT: begin
        // read entry j+1 while writing the previous one, entry j, to j-1
        if (rd_idx_r < count_r) begin
          mem_rd_en   = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
          cmp_idx_nxt = rd_idx_r;
          rv_nxt      = 1'b1;
        end
        if (rv_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(cmp_idx_r - 1'b1);
          mem_wr_data = mem_rd_data;
        end
        if (!(rd_idx_r < count_r) && !rv_r) begin
          count_nxt      = count_r - 1'b1;
          res_status_nxt = ST_OK;
          res_pos_nxt    = slot_r + 1'b1;
          state_nxt      = S_OUT;
        end
      end

      S_OUT: begin
        // load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = pos_wide[OUT_W-1:0];
          out_count_nxt  = count_wide[OUT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_count_r;

endmodule

// File: verif/testbench.sv
module testbench;
  import ont_pkg::*;

  // geometry of the instance under test
  localparam int TBL_DEPTH = DEPTH_DEF;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES_DEF);
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1630;
  localparam int PHASE_ITEMS = 550;
  localparam int HOLD_CYCLES = 600;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct {
    status_t status;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] entry_count;
  } dir_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    bit typed;
    dir_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = CMD_SEARCH;
  logic [KEY_W-1:0] in_name_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [OUT_W-1:0] out_position;
  logic [OUT_W-1:0] out_entry_count;

  // predicted table contents, in slot order
  logic [KEY_W-1:0] dir_entries[$];
  dir_result_t pending_results[$];

  int fails = 0;
  int cycle_count = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 63;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // opening sequence: empty table, extremes of the key, unknown command
  dir_row_t directed_rows [20] = '{
    '{CMD_SEARCH,  64'h0,                 1'b1, '{ST_MISSING, 8'd0, 8'd0}},
    '{CMD_DELETE,  64'h0,                 1'b1, '{ST_MISSING, 8'd0, 8'd0}},
    '{CMD_UNKNOWN, 64'h5,                 1'b1, '{ST_MISSING, 8'd0, 8'd0}},
    '{CMD_CREATE,  64'h0,                 1'b1, '{ST_OK,      8'd1, 8'd1}},
    '{CMD_CREATE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK,    8'd2, 8'd2}},
    '{CMD_CREATE,  64'h0,                 1'b1, '{ST_EXISTS,  8'd0, 8'd2}},
    '{CMD_CREATE,  64'h8000_0000_0000_0000, 1'b1, '{ST_OK,    8'd3, 8'd3}},
    '{CMD_CREATE,  64'h1,                 1'b1, '{ST_OK,      8'd4, 8'd4}},
    '{CMD_SEARCH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK,    8'd2, 8'd4}},
    '{CMD_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_MISSING, 8'd0, 8'd4}},
    '{CMD_DELETE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{ST_OK,    8'd0, 8'd0}},
    '{CMD_SEARCH,  64'h1,                 1'b0, '{ST_OK,      8'd0, 8'd0}},
    '{CMD_SEARCH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{ST_OK,    8'd0, 8'd0}},
    '{CMD_DELETE,  64'h1,                 1'b0, '{ST_OK,      8'd0, 8'd0}},
    '{CMD_CREATE,  64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '{ST_OK,    8'd0, 8'd0}},
    '{CMD_DELETE,  64'h0,                 1'b0, '{ST_OK,      8'd0, 8'd0}},
    '{CMD_SEARCH,  64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '{ST_OK,    8'd0, 8'd0}},
    '{CMD_CREATE,  64'hA5A5_5A5A_0F0F_F0F0, 1'b0, '{ST_OK,    8'd0, 8'd0}},
    '{CMD_DELETE,  64'h8000_0000_0000_0000, 1'b0, '{ST_OK,    8'd0, 8'd0}},
    '{CMD_SEARCH,  64'h0,                 1'b0, '{ST_OK,      8'd0, 8'd0}}
  };

  ordered_name_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_name_key     (in_name_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // zero-based slot of a key in the predicted table, or -1
  function automatic int locate(logic [KEY_W-1:0] k);
    foreach (dir_entries[i]) begin
      if (dir_entries[i] == k) return i;
    end
    return -1;
  endfunction

  // apply one command to the predicted table and return its answer
  function automatic dir_result_t dir_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] raw_key);
    dir_result_t r;
    logic [KEY_W-1:0] k;
    int slot;
    k = raw_key & KEY_MASK;
    slot = locate(k);
    r.status = ST_MISSING;
    r.position = '0;
    case (c)
      CMD_CREATE: begin
        if (dir_entries.size() >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else if (slot >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          dir_entries.push_back(k);
          r.status = ST_OK;
          r.position = OUT_W'(dir_entries.size());
        end
      end
      CMD_DELETE: begin
        if (slot >= 0) begin
          dir_entries.delete(slot);
          r.status = ST_OK;
          r.position = OUT_W'(slot + 1);
        end
      end
      CMD_SEARCH: begin
        if (slot >= 0) begin
          r.status = ST_OK;
          r.position = OUT_W'(slot + 1);
        end
      end
      default: ;
    endcase
    r.entry_count = OUT_W'(dir_entries.size());
    return r;
  endfunction

  // a key not held in the table
  function automatic logic [KEY_W-1:0] absent_key();
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom} & KEY_MASK; while (locate(k) >= 0);
    return k;
  endfunction

  // a key held in the table, any slot
  function automatic logic [KEY_W-1:0] present_key();
    return dir_entries[$urandom_range(dir_entries.size() - 1)];
  endfunction

  // offer one command, called at a falling edge, returns at a falling edge
  task automatic transfer_command(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                                  input bit typed, input dir_result_t typed_res);
    dir_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_name_key <= k;
    do @(posedge clk); while (in_stall);
    predicted = dir_command(c, k);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      pending_results.push_back(predicted);
    end
    @(negedge clk);
  endtask

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    dir_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: status %0d position %0d count %0d",
               out_status, out_position, out_entry_count);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fails++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_position);
          fails++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          fails++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    dir_result_t no_res;
    bit filling;
    int linger;
    int roll;
    no_res = '{ST_OK, '0, '0};
    filling = 1'b1;
    linger = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    foreach (directed_rows[i]) begin
      transfer_command(directed_rows[i].cmd, directed_rows[i].key,
                       directed_rows[i].typed, directed_rows[i].res);
    end

    // random part: alternate filling to full and draining to empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PHASE_ITEMS) begin
        send_idle_pct = 63;
        recv_idle_pct <= 26;
      end else if (n == 2 * PHASE_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req <= 1'b1;
      end

      roll = $urandom_range(99);
      if (filling) begin
        c = (roll < 70) ? CMD_CREATE : (roll < 80) ? CMD_DELETE :
            (roll < 95) ? CMD_SEARCH : CMD_UNKNOWN;
      end else begin
        c = (roll < 65) ? CMD_DELETE : (roll < 75) ? CMD_CREATE :
            (roll < 95) ? CMD_SEARCH : CMD_UNKNOWN;
      end
      if (dir_entries.size() == 0) begin
        k = absent_key();
      end else if (c == CMD_CREATE) begin
        k = ($urandom_range(99) < 85) ? absent_key() : present_key();
      end else begin
        k = ($urandom_range(99) < 75) ? present_key() : absent_key();
      end
      transfer_command(c, k, 1'b0, no_res);

      // switch direction after lingering at full or empty
      if (filling && dir_entries.size() == TBL_DEPTH) linger++;
      if (!filling && dir_entries.size() == 0) linger++;
      if (filling && linger > 20) begin
        filling = 1'b0;
        linger = 0;
      end else if (!filling && linger > 8) begin
        filling = 1'b1;
        linger = 0;
      end
    end
    in_valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: ordered_name_table.f
hw/rtl/ont_pkg.sv
hw/rtl/ont_mem.sv
hw/rtl/ordered_name_table.sv
verif/testbench.sv
